// ----- design/assert_macros.svh -----
// Assertion macros shared by the sphere generator modules.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define USMG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Condition a implies condition b in the same cycle.
`define USMG_ASSERT_IMP(lbl, a, b) \
  `USMG_ASSERT(lbl, (a) |-> (b))

`endif

// ----- design/usmg_pkg.sv -----
`default_nettype none

package usmg_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgRadius  = 2'd0;
  localparam logic [1:0] CfgRings   = 2'd1;
  localparam logic [1:0] CfgSegments = 2'd2;

  localparam int unsigned CordicSteps = 28;
  localparam int unsigned DivSteps    = 40;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [2:0] {
    PhNorth, PhRing, PhSouth, PhNcap, PhBand1, PhBand2, PhScap, PhDone
  } phase_e;

  typedef enum logic [1:0] {
    KindVertex = 2'd0,
    KindTri    = 2'd1,
    KindDone   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    StIdle, StLdB, StDivB, StCorB, StDivT, StCorT, StMulP, StMulR, StHold
  } ctrl_state_e;

  typedef struct packed {
    logic        div_start;
    logic        cor_start;
    logic        sel_t;
    logic        store_trig;
    logic        mul_p;
    logic        mul_r;
    logic        out_load;
    phase_e      phase;
    logic [7:0]  ring;
    logic [7:0]  seg;
    logic [12:0] base;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } sts_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/usmg_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"

module usmg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              restart_i,
  output logic              in_ready_o,
  input  logic [7:0]        r_eff_i,
  input  logic [7:0]        s_eff_i,
  input  usmg_pkg::sts_t    sts_i,
  output usmg_pkg::cmd_t    cmd_o
);

  usmg_pkg::ctrl_state_e state_q, state_d;
  usmg_pkg::phase_e      phase_q, phase_d, w_phase_q, w_phase_d, eph;
  logic [7:0]  ring_q, ring_d, seg_q, seg_d, w_ring_q, w_ring_d, w_seg_q, w_seg_d;
  logic [7:0]  er, es, es_inc, er_inc;
  logic [12:0] base_q, base_d, w_base_q, w_base_d, eb;
  logic        w_last_q, w_last_d;
  logic        accept;

  assign accept = in_valid_i && in_ready_o;
  assign eph    = restart_i ? usmg_pkg::PhNorth : phase_q;
  assign er     = restart_i ? 8'd0 : ring_q;
  assign es     = restart_i ? 8'd0 : seg_q;
  assign eb     = restart_i ? 13'd0 : base_q;
  assign es_inc = es + 8'd1;
  assign er_inc = er + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= usmg_pkg::StIdle;
      phase_q   <= usmg_pkg::PhNorth;
      ring_q    <= '0;
      seg_q     <= '0;
      base_q    <= '0;
      w_phase_q <= usmg_pkg::PhNorth;
      w_ring_q  <= '0;
      w_seg_q   <= '0;
      w_base_q  <= '0;
      w_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      ring_q    <= ring_d;
      seg_q     <= seg_d;
      base_q    <= base_d;
      w_phase_q <= w_phase_d;
      w_ring_q  <= w_ring_d;
      w_seg_q   <= w_seg_d;
      w_base_q  <= w_base_d;
      w_last_q  <= w_last_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    ring_d    = ring_q;
    seg_d     = seg_q;
    base_d    = base_q;
    w_phase_d = w_phase_q;
    w_ring_d  = w_ring_q;
    w_seg_d   = w_seg_q;
    w_base_d  = w_base_q;
    w_last_d  = w_last_q;
    in_ready_o = (state_q == usmg_pkg::StIdle);
    cmd_o       = '0;
    cmd_o.phase = w_phase_q;
    cmd_o.ring  = w_ring_q;
    cmd_o.seg   = w_seg_q;
    cmd_o.base  = w_base_q;
    cmd_o.last  = w_last_q;
    unique case (state_q)
      usmg_pkg::StIdle: begin
        if (in_valid_i) begin
          w_phase_d = eph;
          w_ring_d  = er;
          w_seg_d   = es;
          w_base_d  = eb;
          w_last_d  = (eph == usmg_pkg::PhScap) && (es_inc >= s_eff_i);
          phase_d   = eph;
          ring_d    = er;
          seg_d     = es;
          base_d    = eb;
          unique case (eph)
            usmg_pkg::PhNorth: begin
              phase_d = usmg_pkg::PhRing;
              ring_d  = 8'd1;
              seg_d   = 8'd0;
            end
            usmg_pkg::PhRing: begin
              seg_d = es_inc;
              if (es_inc > s_eff_i) begin
                seg_d  = 8'd0;
                ring_d = er_inc;
                if (er_inc >= r_eff_i) phase_d = usmg_pkg::PhSouth;
              end
            end
            usmg_pkg::PhSouth: begin
              phase_d = usmg_pkg::PhNcap;
              seg_d   = 8'd0;
            end
            usmg_pkg::PhNcap: begin
              seg_d = es_inc;
              if (es_inc >= s_eff_i) begin
                seg_d   = 8'd0;
                ring_d  = 8'd0;
                base_d  = 13'd1;
                phase_d = (r_eff_i > 8'd2) ? usmg_pkg::PhBand1 : usmg_pkg::PhScap;
              end
            end
            usmg_pkg::PhBand1: phase_d = usmg_pkg::PhBand2;
            usmg_pkg::PhBand2: begin
              seg_d   = es_inc;
              phase_d = usmg_pkg::PhBand1;
              if (es_inc >= s_eff_i) begin
                seg_d  = 8'd0;
                ring_d = er_inc;
                base_d = eb + {5'd0, s_eff_i} + 13'd1;
                if (({1'b0, er} + 9'd3) >= {1'b0, r_eff_i}) phase_d = usmg_pkg::PhScap;
              end
            end
            usmg_pkg::PhScap: begin
              seg_d = es_inc;
              if (es_inc >= s_eff_i) phase_d = usmg_pkg::PhDone;
            end
            default: phase_d = usmg_pkg::PhDone;
          endcase
          state_d = (eph == usmg_pkg::PhRing) ? usmg_pkg::StLdB : usmg_pkg::StHold;
        end
      end
      usmg_pkg::StLdB: begin
        cmd_o.div_start = 1'b1;
        state_d = usmg_pkg::StDivB;
      end
      usmg_pkg::StDivB: begin
        if (!sts_i.busy) begin
          cmd_o.cor_start = 1'b1;
          state_d = usmg_pkg::StCorB;
        end
      end
      usmg_pkg::StCorB: begin
        if (!sts_i.busy) begin
          cmd_o.store_trig = 1'b1;
          cmd_o.div_start  = 1'b1;
          cmd_o.sel_t      = 1'b1;
          state_d = usmg_pkg::StDivT;
        end
      end
      usmg_pkg::StDivT: begin
        cmd_o.sel_t = 1'b1;
        if (!sts_i.busy) begin
          cmd_o.cor_start = 1'b1;
          state_d = usmg_pkg::StCorT;
        end
      end
      usmg_pkg::StCorT: begin
        cmd_o.sel_t = 1'b1;
        if (!sts_i.busy) begin
          cmd_o.store_trig = 1'b1;
          state_d = usmg_pkg::StMulP;
        end
      end
      usmg_pkg::StMulP: begin
        cmd_o.mul_p = 1'b1;
        state_d = usmg_pkg::StMulR;
      end
      usmg_pkg::StMulR: begin
        cmd_o.mul_r = 1'b1;
        state_d = usmg_pkg::StHold;
      end
      usmg_pkg::StHold: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = usmg_pkg::StIdle;
        end
      end
      default: state_d = usmg_pkg::StIdle;
    endcase
  end

  `USMG_ASSERT(a_accept_leaves_idle, accept |=> (state_q != usmg_pkg::StIdle))
  `USMG_ASSERT(a_done_sticks,
    ((phase_q == usmg_pkg::PhDone) && !(accept && restart_i)) |=>
      (phase_q == usmg_pkg::PhDone))
  `USMG_ASSERT_IMP(a_start_only_when_free, cmd_o.cor_start || cmd_o.store_trig,
    !sts_i.busy)

endmodule

`default_nettype wire

// ----- design/usmg_datapath.sv -----
`default_nettype none
`include "assert_macros.svh"

module usmg_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  usmg_pkg::cmd_t      cmd_i,
  output usmg_pkg::sts_t      sts_o,
  input  logic [15:0]         radius_i,
  input  logic [7:0]          r_eff_i,
  input  logic [7:0]          s_eff_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic                last_o,
  output logic signed [16:0]  pos_x_o,
  output logic signed [16:0]  pos_y_o,
  output logic signed [16:0]  pos_z_o,
  output logic signed [15:0]  norm_x_o,
  output logic signed [15:0]  norm_y_o,
  output logic signed [15:0]  norm_z_o,
  output logic [12:0]         index_a_o,
  output logic [12:0]         index_b_o,
  output logic [12:0]         index_c_o
);

  function automatic logic signed [16:0] sat_pos(input logic signed [20:0] v);
    logic signed [16:0] r;
    if (v > 21'sd65535) r = 17'sd65535;
    else if (v < -21'sd65535) r = -17'sd65535;
    else r = v[16:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat_norm(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd16384) r = 16'sd16384;
    else if (v < -18'sd16384) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [17:0] sat_trig(input logic signed [19:0] v);
    logic signed [17:0] r;
    if (v > 20'sd65536) r = 18'sd65536;
    else if (v < -20'sd65536) r = -18'sd65536;
    else r = v[17:0];
    return r;
  endfunction

  // Shared iterative unit: restoring divider or CORDIC rotator.
  logic        busy_q, mode_q, sel_q, last_step;
  logic [5:0]  cnt_q;
  logic [6:0]  rem_q;
  logic [39:0] dq_q;
  logic [7:0]  divisor_q, trial;
  logic        ge;
  logic signed [33:0] x_q, y_q, z_q, dx, dy, atan_s;
  logic [1:0]  quad_q;
  logic signed [33:0] xr, yr;
  logic signed [17:0] c_r, s_r, co, si;
  logic signed [17:0] cb_q, sb_q, ct_q, st_q;
  logic signed [35:0] px_q, pz_q;
  logic signed [34:0] rcb_q;
  logic signed [52:0] rpx_q, rpz_q;
  logic signed [16:0] rad_s;
  logic               out_valid_q;
  logic [12:0] rv, a, south, south_m1, bsc, seg13;
  logic [15:0] south_prod;

  assign last_step = mode_q ? (cnt_q == 6'(usmg_pkg::CordicSteps - 1))
                            : (cnt_q == 6'(usmg_pkg::DivSteps - 1));
  assign trial  = {rem_q, dq_q[39]};
  assign ge     = trial >= divisor_q;
  assign dx     = y_q >>> cnt_q[4:0];
  assign dy     = x_q >>> cnt_q[4:0];
  assign atan_s = $signed({4'd0, usmg_pkg::atan_turn(cnt_q[4:0])});
  assign xr     = x_q + 34'sd8192;
  assign yr     = y_q + 34'sd8192;
  assign c_r    = sat_trig(xr[33:14]);
  assign s_r    = sat_trig(yr[33:14]);
  assign rad_s  = $signed({1'b0, radius_i});

  always_comb begin
    unique case (quad_q)
      2'd0: begin co = c_r;  si = s_r;  end
      2'd1: begin co = -s_r; si = c_r;  end
      2'd2: begin co = -c_r; si = -s_r; end
      default: begin co = s_r; si = -c_r; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mode_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start || cmd_i.cor_start) begin
      busy_q <= 1'b1;
      mode_q <= cmd_i.cor_start;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (last_step) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q     <= '0;
      dq_q      <= cmd_i.sel_t ? {cmd_i.seg, 32'd0} : {1'b0, cmd_i.ring, 31'd0};
      divisor_q <= cmd_i.sel_t ? s_eff_i : r_eff_i;
    end else if (busy_q && !mode_q) begin
      rem_q <= ge ? 7'(trial - divisor_q) : trial[6:0];
      dq_q  <= {dq_q[38:0], ge};
    end
    if (cmd_i.cor_start) begin
      sel_q  <= cmd_i.sel_t;
      quad_q <= dq_q[31:30];
      x_q    <= usmg_pkg::CordicGain;
      y_q    <= '0;
      z_q    <= $signed({4'd0, dq_q[29:0]});
    end else if (busy_q && mode_q) begin
      if (!z_q[33]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_s;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_s;
      end
    end
    if (cmd_i.store_trig) begin
      if (sel_q) begin
        ct_q <= co;
        st_q <= si;
      end else begin
        cb_q <= co;
        sb_q <= si;
      end
    end
    if (cmd_i.mul_p) begin
      px_q  <= sb_q * ct_q;
      pz_q  <= sb_q * st_q;
      rcb_q <= rad_s * cb_q;
    end
    if (cmd_i.mul_r) begin
      rpx_q <= rad_s * px_q;
      rpz_q <= rad_s * pz_q;
    end
  end

  // Triangle indices.
  assign seg13      = {5'd0, cmd_i.seg};
  assign rv         = {5'd0, s_eff_i} + 13'd1;
  assign a          = cmd_i.base + seg13;
  assign south_prod = ({8'd0, r_eff_i} - 16'd1) * ({8'd0, s_eff_i} + 16'd1);
  assign south      = south_prod[12:0] + 13'd2;
  assign south_m1   = south - 13'd1;
  assign bsc        = south_m1 - rv;

  // Rounded products.
  logic signed [52:0] rpx_r, rpz_r;
  logic signed [34:0] rcb_r;
  logic signed [35:0] px_r, pz_r;
  logic signed [17:0] cb_r;
  assign rpx_r = rpx_q + 53'sd2147483648;
  assign rpz_r = rpz_q + 53'sd2147483648;
  assign rcb_r = rcb_q + 35'sd32768;
  assign px_r  = px_q + 36'sd131072;
  assign pz_r  = pz_q + 36'sd131072;
  assign cb_r  = cb_q + 18'sd2;

  assign out_valid_o   = out_valid_q;
  assign sts_o.busy     = busy_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Next output word, chosen by the phase of the request.
  logic [1:0]         kind_d;
  logic               last_d;
  logic signed [16:0] pos_x_d, pos_y_d, pos_z_d;
  logic signed [15:0] norm_x_d, norm_y_d, norm_z_d;
  logic [12:0]        index_a_d, index_b_d, index_c_d;

  always_comb begin
    kind_d    = usmg_pkg::KindTri;
    last_d    = cmd_i.last;
    pos_x_d   = '0;
    pos_y_d   = '0;
    pos_z_d   = '0;
    norm_x_d  = '0;
    norm_y_d  = '0;
    norm_z_d  = '0;
    index_a_d = '0;
    index_b_d = '0;
    index_c_d = '0;
    unique case (cmd_i.phase)
      usmg_pkg::PhNorth: begin
        kind_d   = usmg_pkg::KindVertex;
        pos_y_d  = rad_s;
        norm_y_d = 16'sd16384;
      end
      usmg_pkg::PhSouth: begin
        kind_d   = usmg_pkg::KindVertex;
        pos_y_d  = -rad_s;
        norm_y_d = -16'sd16384;
      end
      usmg_pkg::PhRing: begin
        kind_d   = usmg_pkg::KindVertex;
        pos_x_d  = sat_pos(rpx_r[52:32]);
        pos_y_d  = sat_pos($signed({{2{rcb_r[34]}}, rcb_r[34:16]}));
        pos_z_d  = sat_pos(rpz_r[52:32]);
        norm_x_d = sat_norm(px_r[35:18]);
        norm_y_d = sat_norm($signed({{2{cb_r[17]}}, cb_r[17:2]}));
        norm_z_d = sat_norm(pz_r[35:18]);
      end
      usmg_pkg::PhNcap: begin
        index_b_d = seg13 + 13'd2;
        index_c_d = seg13 + 13'd1;
      end
      usmg_pkg::PhBand1: begin
        index_a_d = a;
        index_b_d = a + 13'd1;
        index_c_d = a + rv;
      end
      usmg_pkg::PhBand2: begin
        index_a_d = a + rv;
        index_b_d = a + 13'd1;
        index_c_d = a + rv + 13'd1;
      end
      usmg_pkg::PhScap: begin
        index_a_d = south_m1;
        index_b_d = bsc + seg13;
        index_c_d = bsc + seg13 + 13'd1;
      end
      default: kind_d = usmg_pkg::KindDone;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_o    <= kind_d;
      last_o    <= last_d;
      pos_x_o   <= pos_x_d;
      pos_y_o   <= pos_y_d;
      pos_z_o   <= pos_z_d;
      norm_x_o  <= norm_x_d;
      norm_y_o  <= norm_y_d;
      norm_z_o  <= norm_z_d;
      index_a_o <= index_a_d;
      index_b_o <= index_b_d;
      index_c_o <= index_c_d;
    end
  end

  `USMG_ASSERT_IMP(a_no_overwrite, cmd_i.out_load, !out_valid_q || out_ready_i)
  `USMG_ASSERT(a_cnt_bounded, busy_q |-> (cnt_q < 6'(usmg_pkg::DivSteps)))
  `USMG_ASSERT_IMP(a_kind_legal, out_valid_q,
    (kind_o == usmg_pkg::KindVertex) || (kind_o == usmg_pkg::KindTri) ||
    (kind_o == usmg_pkg::KindDone))

endmodule

`default_nettype wire

// ----- design/uv_sphere_mesh_generator.sv -----
// A pole vertex, a triangle or the finished word goes from StIdle straight to StHold and is
// loaded into the output register once that register is free; a ring vertex first runs
// through the shared unit for two 40-step bit-serial angle divisions and two 28-step CORDIC
// rotations, then through two multiply stages. One request is worked on at a time; the next
// is taken the cycle after the word is loaded. Reset (asynchronous, active low) restores
// radius 1.0, eight rings and eight segments, and restarts the mesh at the north pole.
`default_nettype none

module uv_sphere_mesh_generator #(
  parameter int unsigned MAX_RINGS    = 64,
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic               last_o,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic [12:0]        index_a_o,
  output logic [12:0]        index_b_o,
  output logic [12:0]        index_c_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  // Configuration registers. Writes are to arrive only while the block is idle; the block
  // does not enforce this and always accepts writes. An index beyond the register list is ignored.
  logic [15:0] radius_q;
  logic [6:0]  rings_q, segs_q;
  logic [7:0]  r_eff, s_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      rings_q  <= 7'd8;
      segs_q   <= 7'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        usmg_pkg::CfgRadius:   radius_q <= cfg_data_i;
        usmg_pkg::CfgRings:    rings_q  <= cfg_data_i[6:0];
        usmg_pkg::CfgSegments: segs_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // The counts are clamped into their legal range before use: at least two rings and
  // three segments, and no more than the configured maxima.
  always_comb begin
    if (rings_q < 7'd2) r_eff = 8'd2;
    else if ({2'b00, rings_q} > 9'(MAX_RINGS)) r_eff = 8'(MAX_RINGS);
    else r_eff = {1'b0, rings_q};
    if (segs_q < 7'd3) s_eff = 8'd3;
    else if ({2'b00, segs_q} > 9'(MAX_SEGMENTS)) s_eff = 8'(MAX_SEGMENTS);
    else s_eff = {1'b0, segs_q};
  end

  // The controller walks the mesh (phase, ring and segment counters) and sequences the
  // datapath; the datapath holds the divider, CORDIC, multipliers and output register.
  usmg_pkg::cmd_t cmd;
  usmg_pkg::sts_t sts;

  usmg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_ready_o (in_ready_o),
    .r_eff_i    (r_eff),
    .s_eff_i    (s_eff),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  usmg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .radius_i    (radius_q),
    .r_eff_i     (r_eff),
    .s_eff_i     (s_eff),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .last_o      (last_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .pos_z_o     (pos_z_o),
    .norm_x_o    (norm_x_o),
    .norm_y_o    (norm_y_o),
    .norm_z_o    (norm_z_o),
    .index_a_o   (index_a_o),
    .index_b_o   (index_b_o),
    .index_c_o   (index_c_o)
  );

endmodule

`default_nettype wire

// ----- verif/tb_uv_sphere_mesh_generator.sv -----
`timescale 1ns / 100ps

module tb_uv_sphere_mesh_generator;

  localparam int unsigned MaxRings    = 64;
  localparam int unsigned MaxSegments = 64;
  // Without any handshake for this many cycles, the block is taken to be hung.
  localparam int unsigned HangLimit   = 4000;
  localparam int unsigned LongHold    = 500;
  localparam longint      TrigGain    = 652032874;

  typedef longint unsigned u64_t;

  // One output word of the block, laid out as its ports.
  typedef struct packed {
    logic [1:0]         kind;
    logic               last;
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [16:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [12:0]        ia;
    logic [12:0]        ib;
    logic [12:0]        ic;
  } mesh_word_t;

  // One row of the directed table. Where typed is set, the word in w is the expected one;
  // otherwise the expected word comes from the mesh predictor.
  typedef struct {
    bit         cfg;
    logic [15:0] rad;
    logic [6:0] rings;
    logic [6:0] segs;
    bit         restart;
    bit         typed;
    mesh_word_t w;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               restart_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         kind_o;
  logic               last_o;
  logic signed [16:0] pos_x_o;
  logic signed [16:0] pos_y_o;
  logic signed [16:0] pos_z_o;
  logic signed [15:0] norm_x_o;
  logic signed [15:0] norm_y_o;
  logic signed [15:0] norm_z_o;
  logic [12:0]        index_a_o;
  logic [12:0]        index_b_o;
  logic [12:0]        index_c_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;

  uv_sphere_mesh_generator #(
    .MAX_RINGS   (MaxRings),
    .MAX_SEGMENTS(MaxSegments)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .last_o     (last_o),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .pos_z_o    (pos_z_o),
    .norm_x_o   (norm_x_o),
    .norm_y_o   (norm_y_o),
    .norm_z_o   (norm_z_o),
    .index_a_o  (index_a_o),
    .index_b_o  (index_b_o),
    .index_c_o  (index_c_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Mirror of the configuration registers and of the mesh walker's position.
  logic [15:0] cfg_radius;
  logic [6:0]  cfg_rings;
  logic [6:0]  cfg_segs;
  usmg_pkg::phase_e walk_phase;
  int unsigned ring_ctr;
  int unsigned seg_ctr;
  int unsigned base_idx;
  longint      atan_tbl [28];

  mesh_word_t  expected_words[$];
  stim_row_t   dir_tbl[$];
  int unsigned err_count;
  int unsigned n_vertex;
  int unsigned n_tri;
  int unsigned n_done;
  int unsigned n_cfg;
  int unsigned n_restart;
  bit          quiet;
  bit          hold_req;

  // The clock runs freely from time zero.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Rounds half up while dropping s fraction bits.
  function automatic longint rnd(input longint v, input int unsigned s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  // Cosine and sine of an angle given in units of 2^-32 turn, both in Q16. The CORDIC
  // covers the first quadrant; the top two bits of the angle fold the result outwards.
  function automatic void sin_cos(input logic [31:0] ang, output longint co, output longint si);
    longint x, y, z, dx, dy, c, s;
    x = TrigGain;
    y = 0;
    z = longint'(ang & 32'h3FFF_FFFF);
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tbl[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tbl[i];
      end
    end
    c = clamp(rnd(x, 14), 65536);
    s = clamp(rnd(y, 14), 65536);
    case (ang[31:30])
      2'd0: begin co = c;  si = s;  end
      2'd1: begin co = -s; si = c;  end
      2'd2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endfunction

  function automatic mesh_word_t make_vertex(input longint px, input longint py, input longint pz,
                                             input longint nx, input longint ny, input longint nz);
    mesh_word_t w;
    w = '0;
    w.kind = usmg_pkg::KindVertex;
    w.px = 17'(clamp(px, 65535));
    w.py = 17'(clamp(py, 65535));
    w.pz = 17'(clamp(pz, 65535));
    w.nx = 16'(clamp(nx, 16384));
    w.ny = 16'(clamp(ny, 16384));
    w.nz = 16'(clamp(nz, 16384));
    return w;
  endfunction

  function automatic mesh_word_t make_tri(input int unsigned a, input int unsigned b,
                                          input int unsigned c);
    mesh_word_t w;
    w = '0;
    w.kind = usmg_pkg::KindTri;
    w.ia = a[12:0];
    w.ib = b[12:0];
    w.ic = c[12:0];
    return w;
  endfunction

  // Works out the next mesh element for one accepted request and advances the walker.
  function automatic mesh_word_t next_element(input logic restart);
    mesh_word_t  w;
    int unsigned r_eff, s_eff, rv, south, a;
    longint      rad, cb, sb, ct, st, px, pz;
    u64_t        ang;
    w = '0;
    r_eff = (cfg_rings < 2) ? 2 : ((cfg_rings > MaxRings) ? MaxRings : cfg_rings);
    s_eff = (cfg_segs < 3) ? 3 : ((cfg_segs > MaxSegments) ? MaxSegments : cfg_segs);
    rv = s_eff + 1;
    south = 2 + (r_eff - 1) * rv;
    rad = longint'(cfg_radius);
    if (restart) begin
      walk_phase = usmg_pkg::PhNorth;
      ring_ctr = 0;
      seg_ctr = 0;
      base_idx = 0;
    end
    case (walk_phase)
      usmg_pkg::PhNorth: begin
        w = make_vertex(0, rad, 0, 0, 16384, 0);
        walk_phase = usmg_pkg::PhRing;
        ring_ctr = 1;
        seg_ctr = 0;
      end
      usmg_pkg::PhRing: begin
        ang = (u64_t'(ring_ctr) << 31) / r_eff;
        sin_cos(ang[31:0], cb, sb);
        ang = (u64_t'(seg_ctr) << 32) / s_eff;
        sin_cos(ang[31:0], ct, st);
        px = sb * ct;
        pz = sb * st;
        w = make_vertex(rnd(rad * px, 32), rnd(rad * cb, 16), rnd(rad * pz, 32),
                        rnd(px, 18), rnd(cb, 2), rnd(pz, 18));
        seg_ctr++;
        if (seg_ctr > s_eff) begin
          seg_ctr = 0;
          ring_ctr++;
          if (ring_ctr >= r_eff) walk_phase = usmg_pkg::PhSouth;
        end
      end
      usmg_pkg::PhSouth: begin
        w = make_vertex(0, -rad, 0, 0, -16384, 0);
        walk_phase = usmg_pkg::PhNcap;
        seg_ctr = 0;
      end
      usmg_pkg::PhNcap: begin
        w = make_tri(0, seg_ctr + 2, seg_ctr + 1);
        seg_ctr++;
        if (seg_ctr >= s_eff) begin
          seg_ctr = 0;
          ring_ctr = 0;
          base_idx = 1;
          walk_phase = (r_eff > 2) ? usmg_pkg::PhBand1 : usmg_pkg::PhScap;
        end
      end
      usmg_pkg::PhBand1: begin
        a = base_idx + seg_ctr;
        w = make_tri(a, a + 1, a + rv);
        walk_phase = usmg_pkg::PhBand2;
      end
      usmg_pkg::PhBand2: begin
        a = base_idx + seg_ctr;
        w = make_tri(a + rv, a + 1, a + rv + 1);
        seg_ctr++;
        walk_phase = usmg_pkg::PhBand1;
        if (seg_ctr >= s_eff) begin
          seg_ctr = 0;
          ring_ctr++;
          base_idx += rv;
          if (ring_ctr + 2 >= r_eff) walk_phase = usmg_pkg::PhScap;
        end
      end
      usmg_pkg::PhScap: begin
        base_idx = south - 1 - rv;
        w = make_tri(south - 1, base_idx + seg_ctr, base_idx + seg_ctr + 1);
        seg_ctr++;
        if (seg_ctr >= s_eff) begin
          w.last = 1'b1;
          walk_phase = usmg_pkg::PhDone;
        end
      end
      default: begin
        w.kind = usmg_pkg::KindDone;
      end
    endcase
    return w;
  endfunction

  function automatic stim_row_t mk_row(input bit cfg, input int rad, input int rings,
                                       input int segs, input bit restart, input bit typed,
                                       input usmg_pkg::kind_e kind, input bit last,
                                       input int py, input int ny, input int ia, input int ib,
                                       input int ic);
    stim_row_t r;
    r.cfg = cfg;
    r.rad = rad[15:0];
    r.rings = rings[6:0];
    r.segs = segs[6:0];
    r.restart = restart;
    r.typed = typed;
    r.w = '0;
    r.w.kind = kind;
    r.w.last = last;
    r.w.py = 17'(py);
    r.w.ny = 16'(ny);
    r.w.ia = ia[12:0];
    r.w.ib = ib[12:0];
    r.w.ic = ic[12:0];
    return r;
  endfunction

  // Appends one row to the directed table.
  task automatic add_row(input stim_row_t r);
    dir_tbl.insert(dir_tbl.size(), r);
  endtask

  // Appends one word to the queue of expected output words.
  task automatic expect_word(input mesh_word_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint exp);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, exp);
    err_count++;
  endtask

  // Offers one request word and returns once it has been taken. Valid is left high so that
  // a following word can go out back to back; whatever comes next changes it at a falling edge.
  task automatic send_request(input logic restart, input bit typed, input mesh_word_t typed_w);
    mesh_word_t w;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    restart_i = restart;
    do @(posedge clk_i); while (!in_ready_o);
    w = next_element(restart);
    if (typed) w = typed_w;
    expect_word(w);
    if (restart) n_restart++;
  endtask

  // Stops offering and waits until every expected word has come back.
  task automatic drain;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      usmg_pkg::CfgRadius:   cfg_radius = data;
      usmg_pkg::CfgRings:    cfg_rings = data[6:0];
      usmg_pkg::CfgSegments: cfg_segs = data[6:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // The count registers only keep seven bits, so the upper data bits carry random junk.
  task automatic set_mesh(input logic [15:0] rad, input logic [6:0] rings, input logic [6:0] segs);
    drain();
    write_cfg(usmg_pkg::CfgRadius, rad);
    write_cfg(usmg_pkg::CfgRings, {9'($urandom()), rings});
    write_cfg(usmg_pkg::CfgSegments, {9'($urandom()), segs});
  endtask

  // Receiver: ready drops in random bursts, and once for a long stretch so that the output
  // register fills and the block has to refuse further requests while the sender keeps going.
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (LongHold) @(negedge clk_i);
        out_ready_i = 1'b1;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
        out_ready_i = 1'b1;
      end
    end
  end

  // Output checker and watchdog. Each word taken is compared with the oldest expectation.
  initial begin
    mesh_word_t  got, exp;
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= HangLimit) begin
        $display("Timeout: no word moved for %0d cycles", HangLimit);
        $display("Some tests failed");
        $finish;
      end
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = {kind_o, last_o, pos_x_o, pos_y_o, pos_z_o, norm_x_o, norm_y_o, norm_z_o,
               index_a_o, index_b_o, index_c_o};
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word kind", got.kind, -1);
        end else begin
          exp = expected_words.pop_front();
          if (got.kind !== exp.kind) report_mismatch("kind", got.kind, exp.kind);
          if (got.last !== exp.last) report_mismatch("last", got.last, exp.last);
          if (got.px !== exp.px) report_mismatch("pos_x", got.px, exp.px);
          if (got.py !== exp.py) report_mismatch("pos_y", got.py, exp.py);
          if (got.pz !== exp.pz) report_mismatch("pos_z", got.pz, exp.pz);
          if (got.nx !== exp.nx) report_mismatch("norm_x", got.nx, exp.nx);
          if (got.ny !== exp.ny) report_mismatch("norm_y", got.ny, exp.ny);
          if (got.nz !== exp.nz) report_mismatch("norm_z", got.nz, exp.nz);
          if (got.ia !== exp.ia) report_mismatch("index_a", got.ia, exp.ia);
          if (got.ib !== exp.ib) report_mismatch("index_b", got.ib, exp.ib);
          if (got.ic !== exp.ic) report_mismatch("index_c", got.ic, exp.ic);
          case (exp.kind)
            usmg_pkg::KindVertex: n_vertex++;
            usmg_pkg::KindTri:    n_tri++;
            default:              n_done++;
          endcase
        end
      end
    end
  end

  // Stimulus: a directed table first, then randomly configured meshes.
  initial begin
    stim_row_t   row;
    bit          big;
    int unsigned n_items;
    logic [15:0] rad;
    logic [6:0]  rings, segs;
    logic        rs;

    atan_tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
                 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
                 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
    in_valid_i = 1'b0;
    restart_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = usmg_pkg::CfgRadius;
    cfg_data_i = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    err_count = 0;
    n_vertex = 0;
    n_tri = 0;
    n_done = 0;
    n_cfg = 0;
    n_restart = 0;
    // Mirror of the reset state: radius 1.0, eight rings, eight segments, at the north pole.
    cfg_radius = 16'd256;
    cfg_rings = 7'd8;
    cfg_segs = 7'd8;
    walk_phase = usmg_pkg::PhNorth;
    ring_ctr = 0;
    seg_ctr = 0;
    base_idx = 0;

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: the first request gives the north pole without any restart.
    add_row(mk_row(0, 0, 0, 0, 0, 1, usmg_pkg::KindVertex, 0, 256, 16384, 0, 0, 0));
    add_row(mk_row(0, 0, 0, 0, 0, 0, usmg_pkg::KindVertex, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(0, 0, 0, 0, 0, 0, usmg_pkg::KindVertex, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(0, 0, 0, 0, 1, 1, usmg_pkg::KindVertex, 0, 256, 16384, 0, 0, 0));
    // Smallest mesh at the largest radius, walked to the end: one ring of four points whose
    // last angle wraps to a full turn, both caps and no band, then the finished word twice.
    add_row(mk_row(1, 65535, 2, 3, 1, 1, usmg_pkg::KindVertex, 0, 65535, 16384, 0, 0, 0));
    repeat (4) add_row(mk_row(0, 0, 0, 0, 0, 0, usmg_pkg::KindVertex, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(0, 0, 0, 0, 0, 1, usmg_pkg::KindVertex, 0, -65535, -16384, 0, 0, 0));
    add_row(mk_row(0, 0, 0, 0, 0, 1, usmg_pkg::KindTri, 0, 0, 0, 0, 2, 1));
    add_row(mk_row(0, 0, 0, 0, 0, 1, usmg_pkg::KindTri, 0, 0, 0, 0, 3, 2));
    add_row(mk_row(0, 0, 0, 0, 0, 1, usmg_pkg::KindTri, 0, 0, 0, 0, 4, 3));
    add_row(mk_row(0, 0, 0, 0, 0, 1, usmg_pkg::KindTri, 0, 0, 0, 5, 1, 2));
    add_row(mk_row(0, 0, 0, 0, 0, 1, usmg_pkg::KindTri, 0, 0, 0, 5, 2, 3));
    add_row(mk_row(0, 0, 0, 0, 0, 1, usmg_pkg::KindTri, 1, 0, 0, 5, 3, 4));
    add_row(mk_row(0, 0, 0, 0, 0, 1, usmg_pkg::KindDone, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(0, 0, 0, 0, 0, 1, usmg_pkg::KindDone, 0, 0, 0, 0, 0, 0));
    // Zero radius: positions vanish while the normals still point the right way.
    add_row(mk_row(1, 0, 3, 3, 1, 1, usmg_pkg::KindVertex, 0, 0, 16384, 0, 0, 0));
    add_row(mk_row(0, 0, 0, 0, 0, 0, usmg_pkg::KindVertex, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(0, 0, 0, 0, 0, 0, usmg_pkg::KindVertex, 0, 0, 0, 0, 0, 0));
    // Counts below the minimum are clamped up.
    add_row(mk_row(1, 1000, 0, 0, 1, 1, usmg_pkg::KindVertex, 0, 1000, 16384, 0, 0, 0));
    add_row(mk_row(0, 0, 0, 0, 0, 0, usmg_pkg::KindVertex, 0, 0, 0, 0, 0, 0));
    // Counts above the maximum are clamped down, and change in the middle of a mesh.
    add_row(mk_row(1, 65535, 127, 127, 0, 0, usmg_pkg::KindVertex, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(0, 0, 0, 0, 0, 0, usmg_pkg::KindVertex, 0, 0, 0, 0, 0, 0));

    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      if (row.cfg) set_mesh(row.rad, row.rings, row.segs);
      send_request(row.restart, row.typed, row.w);
    end

    // Random meshes. Most settings are small so that whole meshes get walked to the finished
    // state; a few use the largest counts, where only the first rings are reached. A mesh is
    // mostly restarted once it reports finished, and now and then somewhere in the middle.
    for (int p = 0; p < 14; p++) begin
      big = (p % 6 == 1);
      case (p % 3)
        0:       rad = 16'hFFFF;
        1:       rad = 16'($urandom());
        default: rad = (p % 4 == 0) ? 16'd0 : 16'($urandom_range(1, 2048));
      endcase
      rings = big ? ((p == 1) ? 7'd64 : 7'd127) : 7'($urandom_range(0, 6));
      segs = big ? ((p == 1) ? 7'd64 : 7'($urandom_range(65, 127))) : 7'($urandom_range(0, 7));
      set_mesh(rad, rings, segs);
      if (p == 2) hold_req = 1'b1;
      if (p >= 12) quiet = 1'b1;
      n_items = big ? 40 : 150;
      for (int k = 0; k < n_items; k++) begin
        rs = (walk_phase == usmg_pkg::PhDone && $urandom_range(0, 2) == 0) ||
             $urandom_range(0, 199) == 0;
        send_request(rs, 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Checked %0d vertices, %0d triangles and %0d finished words over %0d register writes",
             n_vertex, n_tri, n_done, n_cfg);
    $display("with %0d restarts, clamped counts, zero and full radius, and output back-pressure.",
             n_restart);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
